>>> design/lpc_pkg.sv
// ----------------------------------------------------------------------------
// Linked peak compressor package
// Constants, register indexes and arithmetic helpers of the compressor.
// ----------------------------------------------------------------------------
package lpc_pkg;

   localparam int SAMPLE_W = 24;
   localparam int PROD_W   = 68;

   localparam logic signed [33:0] DB_TO_LOG2_Q24 = 34'sd2786635;
   localparam logic signed [33:0] LN2_Q30        = 34'sd744261118;
   localparam logic [12:0]        RATIO_MIN_Q8   = 13'd307;
   localparam logic [12:0]        RATIO_UNITY_Q8 = 13'd256;
   localparam logic [23:0]        GAIN_UNITY     = 24'h800000;
   localparam logic [3:0]         EXP_TERMS      = 4'd10;

   // The smoothing step divides by five as a multiply by ceil(2^28 / 5) and a
   // shift by 28, which is exact for numerators below 2^26.
   localparam logic signed [33:0] SMOOTH_RECIP = 34'sd53687092;
   localparam int                 SMOOTH_SHIFT = 28;

   localparam logic [2:0] REG_ENABLE    = 3'd0;
   localparam logic [2:0] REG_CHANNELS  = 3'd1;
   localparam logic [2:0] REG_THRESHOLD = 3'd2;
   localparam logic [2:0] REG_RATIO     = 3'd3;
   localparam logic [2:0] REG_MAKEUP    = 3'd4;
   localparam logic [2:0] REG_ATTACK    = 3'd5;
   localparam logic [2:0] REG_RELEASE   = 3'd6;

   // Arithmetic shift right by sh with rounding half away from zero.
   function automatic logic signed [PROD_W-1:0] round_shr(
      input logic signed [PROD_W-1:0] v, input int sh);
      logic signed [PROD_W-1:0] half;
      half = 68'sd1 <<< (sh - 1);
      if (v >= 0) begin
         return (v + half) >>> sh;
      end
      return -(((-v) + half) >>> sh);
   endfunction

   // Unsigned shift right by s with rounding, result in Q1.23.
   function automatic logic [23:0] round_pow(input logic [31:0] v, input logic [4:0] s);
      logic [32:0] t;
      t = ({1'b0, v} + (33'd1 << (s - 5'd1))) >> s;
      return t[23:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [PROD_W-1:0] y);
      if (y > 68'sd8388607) begin
         return 24'sh7FFFFF;
      end
      if (y < -68'sd8388608) begin
         return 24'sh800000;
      end
      return y[SAMPLE_W-1:0];
   endfunction

endpackage

>>> design/linked_peak_compressor_unit.sv
// ----------------------------------------------------------------------------
// Linked peak compressor
// Stereo feed-forward peak compressor with a hard knee and makeup gain.
// ----------------------------------------------------------------------------
// A request carries one stereo frame (req_left_in, req_right_in, Q1.23) and is
// taken when req_valid is high and req_stall is low. Each request gives one
// result on rsp_left_out / rsp_right_out under rsp_valid, taken when rsp_stall
// is low. The block works on one frame at a time and stalls the request side
// until that frame's result sits in the output register.
// All math runs through one shared 34x34 multiplier stepped by a sequencer; a
// radix-2 divider serves the ratio only, and the divisions by the series index
// and by five are reciprocal multiplies. With compression enabled a silent
// envelope skips the log2 step, a level below the threshold skips the ratio
// divide, and a level above it runs that divide and may run a second 2^x
// series; a frame that passes through when disabled skips the math. The next
// request is taken in the cycle after the result is loaded. A finished
// result waits in the output register while the receiver stalls; if that
// register is still full, the block holds its last step and keeps the
// request side stalled. Reset clears the envelope, sets the smoothed gain
// to unity and loads the register defaults.
module linked_peak_compressor_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [lpc_pkg::SAMPLE_W-1:0] req_left_in,
   input  logic signed [lpc_pkg::SAMPLE_W-1:0] req_right_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [lpc_pkg::SAMPLE_W-1:0] rsp_left_out,
   output logic signed [lpc_pkg::SAMPLE_W-1:0] rsp_right_out,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [4:0]                      paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import lpc_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_ENV_M = 5'd1;
   localparam logic [4:0] S_ENV_W = 5'd2;
   localparam logic [4:0] S_THR_M = 5'd3;
   localparam logic [4:0] S_THR_W = 5'd4;
   localparam logic [4:0] S_LG_M  = 5'd5;
   localparam logic [4:0] S_LG_W  = 5'd6;
   localparam logic [4:0] S_CMP   = 5'd7;
   localparam logic [4:0] S_OV_M  = 5'd8;
   localparam logic [4:0] S_OV_W  = 5'd9;
   localparam logic [4:0] S_DIV   = 5'd10;
   localparam logic [4:0] S_AT    = 5'd11;
   localparam logic [4:0] S_AT2   = 5'd12;
   localparam logic [4:0] S_EXX_M = 5'd13;
   localparam logic [4:0] S_EXX_W = 5'd14;
   localparam logic [4:0] S_EXT_M = 5'd15;
   localparam logic [4:0] S_EXT_W = 5'd16;
   localparam logic [4:0] S_EXT_D = 5'd17;
   localparam logic [4:0] S_SM    = 5'd18;
   localparam logic [4:0] S_SM_D  = 5'd19;
   localparam logic [4:0] S_MK_M  = 5'd20;
   localparam logic [4:0] S_MK_W  = 5'd21;
   localparam logic [4:0] S_MK2   = 5'd22;
   localparam logic [4:0] S_G_M   = 5'd23;
   localparam logic [4:0] S_G_W   = 5'd24;
   localparam logic [4:0] S_Y0_M  = 5'd25;
   localparam logic [4:0] S_Y0_W  = 5'd26;
   localparam logic [4:0] S_Y1_M  = 5'd27;
   localparam logic [4:0] S_Y1_W  = 5'd28;
   localparam logic [4:0] S_DONE  = 5'd29;

   // Configuration registers
   logic               enable_ff;
   logic [1:0]         channel_count_ff;
   logic signed [10:0] threshold_ff;
   logic [12:0]        ratio_ff;
   logic [8:0]         makeup_ff;
   logic [15:0]        attack_ff;
   logic [15:0]        release_ff;

   // Sequencer and datapath registers
   logic [4:0]  state_ff, exp_ret_ff;
   logic signed [23:0] x0_ff, x1_ff, outl_ff, outr_ff;
   logic        stereo_ff;
   logic [23:0] peak_ff, env_ff, sg_ff, target_ff;
   logic signed [21:0] thr_ff;
   logic [4:0]  p_ff;
   logic [31:0] m_ff;
   logic [15:0] frac_ff;
   logic [3:0]  it_ff;
   logic [20:0] over_ff;
   logic [3:0]  n_ff;
   logic [15:0] ea_ff;
   logic [29:0] ex_x_ff;
   logic [30:0] term_ff;
   logic [31:0] sum_ff;
   logic [3:0]  k_ff;
   logic [33:0] quo_ff;
   logic [12:0] rem_ff, dvs_ff;
   logic [5:0]  cnt_ff;
   logic        neg_ff;
   logic [3:0]  sh_ff;
   logic [29:0] mk_ff, g_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic        rsp_valid_ff;
   logic signed [23:0] rsp_left_ff, rsp_right_ff;

   // Combinational helpers
   logic        cfg_write, stereo_now;
   logic signed [24:0] l_ext, r_ext;
   logic [23:0] abs_l, abs_r, peak_now;
   logic signed [25:0] env_d;
   logic [15:0] coef;
   logic signed [PROD_W-1:0] env_rnd, thr_rnd, mk_rnd, y_rnd, g_sum;
   logic [25:0] env_new;
   logic [4:0]  lead_p;
   logic [31:0] env_wide, m_init;
   logic [32:0] sq;
   logic signed [6:0]  pm23;
   logic signed [22:0] lg;
   logic signed [23:0] over_full;
   logic [12:0] r_eff, r_m;
   logic [33:0] num;
   logic [19:0] gq;
   logic signed [24:0] tdiff;
   logic [23:0] tmag;
   logic [24:0] sm_num;
   logic [23:0] sm_q;
   logic [31:0] rk_mul;
   logic [5:0]  rk_sh;
   logic [30:0] kq;
   logic [47:0] mk_sh, mk_full;
   logic [13:0] rem2;
   logic        ge;
   logic signed [33:0] mul_a, mul_b;
   logic signed [23:0] y_sat;

   assign cfg_write  = psel && penable && pwrite;
   assign pready     = 1'b1;
   assign stereo_now = channel_count_ff[1];

   always_comb begin
      unique case (paddr[4:2])
         REG_ENABLE:    prdata = {31'd0, enable_ff};
         REG_CHANNELS:  prdata = {30'd0, channel_count_ff};
         REG_THRESHOLD: prdata = 32'(threshold_ff);
         REG_RATIO:     prdata = {19'd0, ratio_ff};
         REG_MAKEUP:    prdata = {23'd0, makeup_ff};
         REG_ATTACK:    prdata = {16'd0, attack_ff};
         REG_RELEASE:   prdata = {16'd0, release_ff};
         default:       prdata = 32'd0;
      endcase
   end

   assign l_ext    = {req_left_in[23], req_left_in};
   assign r_ext    = {req_right_in[23], req_right_in};
   assign abs_l    = l_ext[24] ? 24'(-l_ext) : 24'(l_ext);
   assign abs_r    = r_ext[24] ? 24'(-r_ext) : 24'(r_ext);
   assign peak_now = (stereo_now && abs_r > abs_l) ? abs_r : abs_l;

   assign env_d   = $signed({2'b00, env_ff}) - $signed({2'b00, peak_ff});
   assign coef    = (peak_ff > env_ff) ? attack_ff : release_ff;
   assign env_rnd = round_shr(prod_ff, 16);
   assign env_new = {2'b00, peak_ff} + env_rnd[25:0];
   assign thr_rnd = round_shr(prod_ff, 12);
   assign mk_rnd  = thr_rnd;

   always_comb begin
      lead_p = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (env_ff[i]) begin
            lead_p = 5'(i);
         end
      end
   end

   assign env_wide = {8'd0, env_ff};
   assign m_init   = env_wide << (5'd31 - lead_p);
   assign sq       = prod_ff[63:31];

   assign pm23      = $signed({2'b00, p_ff}) - 7'sd23;
   assign lg        = {pm23, frac_ff};
   assign over_full = 24'(lg) - 24'(thr_ff);

   assign r_eff = (ratio_ff < RATIO_MIN_Q8) ? RATIO_MIN_Q8 : ratio_ff;
   assign r_m   = r_eff - RATIO_UNITY_Q8;
   assign num   = prod_ff[33:0] + {22'd0, r_eff[12:1]};
   assign gq    = quo_ff[19:0];

   assign tdiff  = $signed({1'b0, target_ff}) - $signed({1'b0, sg_ff});
   assign tmag   = tdiff[24] ? 24'(-tdiff) : 24'(tdiff);
   assign sm_num = {1'b0, tmag} + 25'd2;
   assign sm_q   = 24'(prod_ff >> SMOOTH_SHIFT);

   // Series terms stay below 2^30, so ceil(2^s / k) with s = 30 + ceil(log2 k)
   // gives the exact floor of the division by k.
   always_comb begin
      unique case (k_ff)
         4'd1:    {rk_mul, rk_sh} = {32'd1073741824, 6'd30};
         4'd2:    {rk_mul, rk_sh} = {32'd1073741824, 6'd31};
         4'd3:    {rk_mul, rk_sh} = {32'd1431655766, 6'd32};
         4'd4:    {rk_mul, rk_sh} = {32'd1073741824, 6'd32};
         4'd5:    {rk_mul, rk_sh} = {32'd1717986919, 6'd33};
         4'd6:    {rk_mul, rk_sh} = {32'd1431655766, 6'd33};
         4'd7:    {rk_mul, rk_sh} = {32'd1227133514, 6'd33};
         4'd8:    {rk_mul, rk_sh} = {32'd1073741824, 6'd33};
         4'd9:    {rk_mul, rk_sh} = {32'd1908874354, 6'd34};
         4'd10:   {rk_mul, rk_sh} = {32'd1717986919, 6'd34};
         default: {rk_mul, rk_sh} = {32'd1073741824, 6'd30};
      endcase
   end

   assign kq = 31'(prod_ff >> rk_sh);

   assign mk_sh   = {16'd0, sum_ff} << sh_ff;
   assign mk_full = (mk_sh + 48'd64) >> 7;
   assign g_sum   = prod_ff + (68'sd1 <<< 22);
   assign y_rnd   = round_shr(prod_ff, 23);
   assign y_sat   = sat_sample(y_rnd);

   assign rem2 = {rem_ff, quo_ff[33]};
   assign ge   = rem2 >= {1'b0, dvs_ff};

   // Operand select for the shared multiplier
   always_comb begin
      mul_a = 34'sd0;
      mul_b = 34'sd0;
      unique case (state_ff)
         S_ENV_M: begin
            mul_a = 34'(env_d);
            mul_b = {18'd0, coef};
         end
         S_THR_M: begin
            mul_a = 34'(threshold_ff);
            mul_b = DB_TO_LOG2_Q24;
         end
         S_LG_M: begin
            mul_a = {2'b00, m_ff};
            mul_b = {2'b00, m_ff};
         end
         S_OV_M: begin
            mul_a = {13'd0, over_ff};
            mul_b = {21'd0, r_m};
         end
         S_EXX_M: begin
            mul_a = {18'd0, ea_ff};
            mul_b = LN2_Q30;
         end
         S_EXT_M: begin
            mul_a = {3'd0, term_ff};
            mul_b = {4'd0, ex_x_ff};
         end
         S_EXT_W: begin
            mul_a = {4'd0, prod_ff[59:30]};
            mul_b = {2'd0, rk_mul};
         end
         S_SM: begin
            mul_a = {9'd0, sm_num};
            mul_b = SMOOTH_RECIP;
         end
         S_MK_M: begin
            mul_a = {25'd0, makeup_ff};
            mul_b = DB_TO_LOG2_Q24;
         end
         S_G_M: begin
            mul_a = {10'd0, sg_ff};
            mul_b = {4'd0, mk_ff};
         end
         S_Y0_M: begin
            mul_a = 34'(x0_ff);
            mul_b = {4'd0, g_ff};
         end
         S_Y1_M: begin
            mul_a = 34'(x1_ff);
            mul_b = {4'd0, g_ff};
         end
         default: begin
            mul_a = 34'sd0;
            mul_b = 34'sd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= 1'b0;
         channel_count_ff <= 2'd2;
         threshold_ff     <= -11'sd320;
         ratio_ff         <= 13'd1024;
         makeup_ff        <= 9'd0;
         attack_ff        <= 16'd62000;
         release_ff       <= 16'd65000;
      end else if (cfg_write) begin
         unique case (paddr[4:2])
            REG_ENABLE:    enable_ff        <= pwdata[0];
            REG_CHANNELS:  channel_count_ff <= pwdata[1:0];
            REG_THRESHOLD: threshold_ff     <= pwdata[10:0];
            REG_RATIO:     ratio_ff         <= pwdata[12:0];
            REG_MAKEUP:    makeup_ff        <= pwdata[8:0];
            REG_ATTACK:    attack_ff        <= pwdata[15:0];
            REG_RELEASE:   release_ff       <= pwdata[15:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         env_ff       <= 24'd0;
         sg_ff        <= GAIN_UNITY;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  x0_ff     <= req_left_in;
                  x1_ff     <= stereo_now ? req_right_in : 24'sd0;
                  stereo_ff <= stereo_now;
                  peak_ff   <= peak_now;
                  if (enable_ff) begin
                     state_ff <= S_ENV_M;
                  end else begin
                     outl_ff  <= req_left_in;
                     outr_ff  <= stereo_now ? req_right_in : 24'sd0;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_ENV_M: state_ff <= S_ENV_W;
            S_ENV_W: begin
               env_ff   <= env_new[23:0];
               state_ff <= S_THR_M;
            end
            S_THR_M: state_ff <= S_THR_W;
            S_THR_W: begin
               thr_ff <= thr_rnd[21:0];
               if (env_ff == 24'd0) begin
                  // A silent envelope never compresses.
                  target_ff <= GAIN_UNITY;
                  state_ff  <= S_SM;
               end else begin
                  p_ff     <= lead_p;
                  m_ff     <= m_init;
                  frac_ff  <= 16'd0;
                  it_ff    <= 4'd0;
                  state_ff <= S_LG_M;
               end
            end
            S_LG_M: state_ff <= S_LG_W;
            S_LG_W: begin
               // Each squaring of the mantissa yields one fraction bit of log2.
               if (sq[32]) begin
                  m_ff <= sq[32:1];
                  frac_ff[4'd15 - it_ff] <= 1'b1;
               end else begin
                  m_ff <= sq[31:0];
               end
               it_ff    <= it_ff + 4'd1;
               state_ff <= (it_ff == 4'd15) ? S_CMP : S_LG_M;
            end
            S_CMP: begin
               if (lg > 23'(thr_ff)) begin
                  over_ff  <= over_full[20:0];
                  state_ff <= S_OV_M;
               end else begin
                  target_ff <= GAIN_UNITY;
                  state_ff  <= S_SM;
               end
            end
            S_OV_M: state_ff <= S_OV_W;
            S_OV_W: begin
               quo_ff   <= num;
               rem_ff   <= 13'd0;
               cnt_ff   <= 6'd0;
               dvs_ff   <= r_eff;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff <= ge ? 13'(rem2 - {1'b0, dvs_ff}) : rem2[12:0];
               quo_ff <= {quo_ff[32:0], ge};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd33) begin
                  state_ff <= S_AT;
               end
            end
            S_AT: begin
               n_ff <= gq[19:16];
               if (gq[15:0] == 16'd0) begin
                  target_ff <= round_pow(32'h40000000, 5'd7 + {1'b0, gq[19:16]});
                  state_ff  <= S_SM;
               end else begin
                  ea_ff      <= 16'(17'h10000 - {1'b0, gq[15:0]});
                  exp_ret_ff <= S_AT2;
                  state_ff   <= S_EXX_M;
               end
            end
            S_AT2: begin
               target_ff <= round_pow(sum_ff, 5'd8 + {1'b0, n_ff});
               state_ff  <= S_SM;
            end
            S_EXX_M: state_ff <= S_EXX_W;
            S_EXX_W: begin
               ex_x_ff  <= prod_ff[45:16];
               sum_ff   <= 32'h40000000;
               term_ff  <= 31'h40000000;
               k_ff     <= 4'd1;
               state_ff <= S_EXT_M;
            end
            S_EXT_M: state_ff <= S_EXT_W;
            S_EXT_W: state_ff <= S_EXT_D;
            S_EXT_D: begin
               term_ff <= kq;
               sum_ff  <= sum_ff + {1'b0, kq};
               if (k_ff == EXP_TERMS) begin
                  state_ff <= exp_ret_ff;
               end else begin
                  k_ff     <= k_ff + 4'd1;
                  state_ff <= S_EXT_M;
               end
            end
            S_SM: begin
               neg_ff   <= tdiff[24];
               state_ff <= S_SM_D;
            end
            S_SM_D: begin
               sg_ff    <= neg_ff ? sg_ff - sm_q : sg_ff + sm_q;
               state_ff <= S_MK_M;
            end
            S_MK_M: state_ff <= S_MK_W;
            S_MK_W: begin
               ea_ff      <= mk_rnd[15:0];
               sh_ff      <= mk_rnd[19:16];
               exp_ret_ff <= S_MK2;
               state_ff   <= S_EXX_M;
            end
            S_MK2: begin
               mk_ff    <= mk_full[29:0];
               state_ff <= S_G_M;
            end
            S_G_M: state_ff <= S_G_W;
            S_G_W: begin
               g_ff     <= g_sum[52:23];
               state_ff <= S_Y0_M;
            end
            S_Y0_M: state_ff <= S_Y0_W;
            S_Y0_W: begin
               outl_ff  <= y_sat;
               state_ff <= S_Y1_M;
            end
            S_Y1_M: state_ff <= S_Y1_W;
            S_Y1_W: begin
               outr_ff  <= stereo_ff ? y_sat : 24'sd0;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_left_ff  <= outl_ff;
                  rsp_right_ff <= outr_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

endmodule
